// File: sv/lwc_pkg.sv
// Shared types and constants for the lattice walk coverage block.
package lwc_pkg;

    localparam int HALF_W  = 7;    // half_size register width
    localparam int COUNT_W = 14;   // visited_count and cell_total width
    localparam int BOUND_W = 8;    // wide enough for coordinates up to 2*64
    localparam int DIR_W   = 2;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [HALF_W-1:0] HALF_RESET = 7'd64;

    // Register index, taken from the word address.
    localparam logic REG_HALF_SIZE = 1'b0;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

    // Walk limits derived from the bound, in offset coordinates (origin at MAX_HALF).
    typedef struct packed {
        logic [BOUND_W-1:0] lo;     // coordinate at or below this ends the walk
        logic [BOUND_W-1:0] hi;     // coordinate at or above this ends the walk
        logic [COUNT_W-1:0] total;  // (2n-1) squared
    } lwc_bound_t;

endpackage

// File: sv/lattice_walk_coverage.sv
// Top level of the lattice walk coverage block: register port, bound, walker and map memory.
//
// Usage:
//   Input channel (s_valid / s_ready / s_direction): one step per transaction,
//   0 up, 1 right, 2 down, 3 left. The walker marks its cell, then moves.
//   Result channel (m_valid / m_ready / m_visited_count / m_cell_total): one
//   transaction when a step reaches the edge of the square of half-width n,
//   carrying the distinct cells visited and (2n-1) squared.
//   Register port (APB style, pready tied high): half_size at byte address 0.
//   Writing it ends the current walk without a result and restarts at the origin.
//
// Timing:
//   Each step is a read-modify-write: accept and read the map row of the
//   current x, then set the bit, write the row back and move. The map read
//   is registered, so s_ready stays low after each accept until the update
//   is done. A result appears the cycle after the ending step's update. The
//   map is then cleared one row a cycle, all 2*MAX_HALF rows (128 by default),
//   with s_ready low. The same clear pass runs after reset and after a half_size write.
//   A stalled receiver holds the result in the output register; steps that do
//   not end the walk still proceed, and a walk-ending step waits until the slot frees.
module lattice_walk_coverage
    import lwc_pkg::*;
#(
    parameter int MAX_HALF = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DIR_W-1:0]   s_direction,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_visited_count,
    output logic [COUNT_W-1:0] m_cell_total
);

    localparam int SIDE  = 2 * MAX_HALF;
    localparam int ROW_W = $clog2(SIDE);

    logic [HALF_W-1:0] half_size_reg;
    logic              hs_write;
    lwc_bound_t        bound;

    logic              mem_wr_en;
    logic [ROW_W-1:0]  mem_wr_addr;
    logic [SIDE-1:0]   mem_wr_data;
    logic              mem_rd_en;
    logic [ROW_W-1:0]  mem_rd_addr;
    logic [SIDE-1:0]   mem_rd_data;

    // Decode on the word address; writes to other words drop.
    assign pready   = 1'b1;
    assign hs_write = psel && penable && pwrite && (paddr[2] == REG_HALF_SIZE);
    assign prdata   = (paddr[2] == REG_HALF_SIZE) ? PDATA_W'(half_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_size_reg <= HALF_RESET;
        end else if (hs_write) begin
            half_size_reg <= pwdata[HALF_W-1:0];
        end
    end

    lwc_bound #(
        .MAX_HALF (MAX_HALF)
    ) u_bound (
        .aclk      (aclk),
        .half_size (half_size_reg),
        .bound     (bound)
    );

    lwc_walker #(
        .MAX_HALF (MAX_HALF),
        .SIDE     (SIDE),
        .ROW_W    (ROW_W)
    ) u_walker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .restart         (hs_write),
        .bound           (bound),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_direction     (s_direction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_visited_count (m_visited_count),
        .m_cell_total    (m_cell_total),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data)
    );

    lwc_map_ram #(
        .DEPTH  (SIDE),
        .ADDR_W (ROW_W),
        .DATA_W (SIDE)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// File: sv/lwc_map_ram.sv
// Visited map storage: one row per x, one bit per y, registered read.
module lwc_map_ram
    import lwc_pkg::*;
#(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 128
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/lwc_bound.sv
// Bound limits: clamp half_size, derive the edge coordinates and the cell total.
module lwc_bound
    import lwc_pkg::*;
#(
    parameter int MAX_HALF = 64
) (
    input  logic              aclk,
    input  logic [HALF_W-1:0] half_size,
    output lwc_bound_t        bound
);

    logic [HALF_W-1:0]    n_eff;
    logic [BOUND_W-1:0]   lo_reg;
    logic [BOUND_W-1:0]   hi_reg;
    logic [BOUND_W-1:0]   side_reg;
    logic [2*BOUND_W-1:0] prod;
    logic [COUNT_W-1:0]   total_reg;

    // Clamp to [1, MAX_HALF].
    always_comb begin
        n_eff = half_size;
        if (half_size == '0) begin
            n_eff = HALF_W'(1);
        end else if (half_size > HALF_W'(MAX_HALF)) begin
            n_eff = HALF_W'(MAX_HALF);
        end
    end

    assign prod = side_reg * side_reg;

    always_ff @(posedge aclk) begin
        lo_reg    <= BOUND_W'(MAX_HALF) - BOUND_W'(n_eff);
        hi_reg    <= BOUND_W'(MAX_HALF) + BOUND_W'(n_eff);
        side_reg  <= {n_eff, 1'b0} - BOUND_W'(1);
        total_reg <= prod[COUNT_W-1:0];
    end

    assign bound.lo    = lo_reg;
    assign bound.hi    = hi_reg;
    assign bound.total = total_reg;

endmodule

// File: sv/lwc_walker.sv
// Walk sequencer: row read-modify-write, position and count, clear pass, result register.
module lwc_walker
    import lwc_pkg::*;
#(
    parameter int MAX_HALF = 64,
    parameter int SIDE     = 2 * MAX_HALF,
    parameter int ROW_W    = $clog2(SIDE)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               restart,
    input  lwc_bound_t         bound,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DIR_W-1:0]   s_direction,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_visited_count,
    output logic [COUNT_W-1:0] m_cell_total,
    output logic               mem_wr_en,
    output logic [ROW_W-1:0]   mem_wr_addr,
    output logic [SIDE-1:0]    mem_wr_data,
    output logic               mem_rd_en,
    output logic [ROW_W-1:0]   mem_rd_addr,
    input  logic [SIDE-1:0]    mem_rd_data
);

    localparam int EXT_W = ROW_W + 1;
    localparam logic [ROW_W-1:0] ORIGIN   = ROW_W'(MAX_HALF);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SIDE - 1);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } walk_state_t;

    walk_state_t        state_reg;
    logic [ROW_W-1:0]   clr_cnt_reg;
    logic [ROW_W-1:0]   pos_x_reg;
    logic [ROW_W-1:0]   pos_y_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DIR_W-1:0]   dir_reg;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [COUNT_W-1:0] m_total_reg;

    logic [EXT_W-1:0]   nx;
    logic [EXT_W-1:0]   ny;
    logic               hit;
    logic               end_walk;
    logic               out_free;
    logic               advance;
    logic [COUNT_W-1:0] count_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign mem_rd_en = s_valid && s_ready;
    assign mem_rd_addr = pos_x_reg;

    always_comb begin
        nx = {1'b0, pos_x_reg};
        ny = {1'b0, pos_y_reg};
        case (dir_reg)
            DIR_UP:    ny = {1'b0, pos_y_reg} + EXT_W'(1);
            DIR_RIGHT: nx = {1'b0, pos_x_reg} + EXT_W'(1);
            DIR_DOWN:  ny = {1'b0, pos_y_reg} - EXT_W'(1);
            DIR_LEFT:  nx = {1'b0, pos_x_reg} - EXT_W'(1);
            default:   nx = {1'b0, pos_x_reg};
        endcase

        hit        = mem_rd_data[pos_y_reg];
        count_next = count_reg + COUNT_W'(!hit);
        end_walk   = (BOUND_W'(nx) <= bound.lo) || (BOUND_W'(nx) >= bound.hi)
                  || (BOUND_W'(ny) <= bound.lo) || (BOUND_W'(ny) >= bound.hi);
        out_free   = !m_valid_reg || m_ready;
        // Hold a walk-ending step until the result slot is free.
        advance    = (state_reg == ST_UPDATE) && (!end_walk || out_free);

        mem_wr_en   = 1'b0;
        mem_wr_addr = pos_x_reg;
        mem_wr_data = mem_rd_data | (SIDE'(1) << pos_y_reg);
        if (state_reg == ST_CLEAR) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg;
            mem_wr_data = '0;
        end else if (advance) begin
            mem_wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pos_x_reg   <= ORIGIN;
            pos_y_reg   <= ORIGIN;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (restart) begin
                state_reg   <= ST_CLEAR;
                clr_cnt_reg <= '0;
                pos_x_reg   <= ORIGIN;
                pos_y_reg   <= ORIGIN;
                count_reg   <= '0;
            end else begin
                unique case (state_reg)
                    ST_CLEAR: begin
                        clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
                        if (clr_cnt_reg == LAST_ROW) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (s_valid) begin
                            dir_reg   <= s_direction;
                            state_reg <= ST_UPDATE;
                        end
                    end
                    ST_UPDATE: begin
                        if (advance) begin
                            if (end_walk) begin
                                m_valid_reg <= 1'b1;
                                m_count_reg <= count_next;
                                m_total_reg <= bound.total;
                                pos_x_reg   <= ORIGIN;
                                pos_y_reg   <= ORIGIN;
                                count_reg   <= '0;
                                clr_cnt_reg <= '0;
                                state_reg   <= ST_CLEAR;
                            end else begin
                                pos_x_reg <= nx[ROW_W-1:0];
                                pos_y_reg <= ny[ROW_W-1:0];
                                count_reg <= count_next;
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        state_reg <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_visited_count = m_count_reg;
    assign m_cell_total    = m_total_reg;

endmodule

// File: sv/lwc_checker.sv
// Port-level checks for the lattice walk coverage block, bound to the top level.
module lwc_checker
    import lwc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COUNT_W-1:0] m_visited_count,
    input logic [COUNT_W-1:0] m_cell_total
);

    // Reset starts a clear pass, so no step is taken in the next cycle.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // A step is never accepted back to back with the previous one.
    a_step_two_cycles: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("step accepted on back-to-back cycles");

    // A result never reports more cells than the square holds, nor none.
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_visited_count <= m_cell_total) && (m_visited_count != '0))
        else $error("visited_count out of range");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visited_count)
                                && $stable(m_cell_total))
        else $error("stalled result changed");

endmodule

bind lattice_walk_coverage lwc_checker u_lwc_checker (.*);

// File: dv/tb_top.sv
// Testbench for lattice_walk_coverage: directed stimulus table, then random walks run in phases.
`timescale 1ns / 100ps

module tb_top
    import lwc_pkg::*;
();

    localparam int MAX_HALF    = 64;
    localparam int MAP_SIDE    = 2 * MAX_HALF;
    // Longest quiet stretch the block may need after a step: update, result, map clear.
    localparam int SETTLE_CYC  = 2 * MAX_HALF + 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 92;

    // Register 0 is half_size; the other word address decodes to no register.
    localparam logic [PADDR_W-1:0] ADDR_HALF_SIZE = {REG_HALF_SIZE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE     = {~REG_HALF_SIZE, 2'b00};

    typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic [COUNT_W-1:0] visited_count;
        logic [COUNT_W-1:0] cell_total;
    } walk_result_t;

    // One directed row: a step, or a register write. A step row may carry a
    // hand-written result; otherwise the walk model supplies it.
    typedef struct packed {
        row_kind_t          kind;
        logic [DIR_W-1:0]   dir;
        logic [PADDR_W-1:0] addr;
        logic [PDATA_W-1:0] data;
        logic               has_want;
        walk_result_t       want;
    } walk_row_t;

    walk_row_t directed_rows [25] = '{
        // default bound of 64: a small loop that comes back to the origin
        '{ROW_STEP,  DIR_UP,    ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_STEP,  DIR_RIGHT, ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_STEP,  DIR_DOWN,  ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_STEP,  DIR_LEFT,  ADDR_HALF_SIZE, '0, 1'b0, '0},
        // a bound of zero acts as one: every step ends the walk at once
        '{ROW_WRITE, DIR_UP,    ADDR_HALF_SIZE, 32'd0, 1'b0, '0},
        '{ROW_STEP,  DIR_UP,    ADDR_HALF_SIZE, '0, 1'b1, '{14'd1, 14'd1}},
        '{ROW_WRITE, DIR_UP,    ADDR_HALF_SIZE, 32'd1, 1'b0, '0},
        '{ROW_STEP,  DIR_RIGHT, ADDR_HALF_SIZE, '0, 1'b1, '{14'd1, 14'd1}},
        '{ROW_STEP,  DIR_DOWN,  ADDR_HALF_SIZE, '0, 1'b1, '{14'd1, 14'd1}},
        '{ROW_STEP,  DIR_LEFT,  ADDR_HALF_SIZE, '0, 1'b1, '{14'd1, 14'd1}},
        // bound of two: revisit the origin, then leave through the top
        '{ROW_WRITE, DIR_UP,    ADDR_HALF_SIZE, 32'd2, 1'b0, '0},
        '{ROW_STEP,  DIR_RIGHT, ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_STEP,  DIR_LEFT,  ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_STEP,  DIR_UP,    ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_STEP,  DIR_UP,    ADDR_HALF_SIZE, '0, 1'b1, '{14'd3, 14'd9}},
        // a write to the unused address must leave the walk untouched
        '{ROW_STEP,  DIR_DOWN,  ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_WRITE, DIR_UP,    ADDR_SPARE,     32'd1, 1'b0, '0},
        '{ROW_STEP,  DIR_DOWN,  ADDR_HALF_SIZE, '0, 1'b1, '{14'd2, 14'd9}},
        // rewriting half_size mid-walk drops the walk without a result
        '{ROW_STEP,  DIR_LEFT,  ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_WRITE, DIR_UP,    ADDR_HALF_SIZE, 32'd2, 1'b0, '0},
        '{ROW_STEP,  DIR_LEFT,  ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_STEP,  DIR_LEFT,  ADDR_HALF_SIZE, '0, 1'b1, '{14'd2, 14'd9}},
        // all-ones write: 127 in the register, clamped to the largest bound
        '{ROW_WRITE, DIR_UP,    ADDR_HALF_SIZE, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_STEP,  DIR_DOWN,  ADDR_HALF_SIZE, '0, 1'b0, '0},
        '{ROW_WRITE, DIR_UP,    ADDR_HALF_SIZE, 32'd64, 1'b0, '0}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [DIR_W-1:0]   s_direction = DIR_UP;
    logic               m_valid;
    logic               m_ready = 1'b1;
    logic [COUNT_W-1:0] m_visited_count;
    logic [COUNT_W-1:0] m_cell_total;

    // Walk model state: raw register, walker position, visited cells and count.
    logic [HALF_W-1:0]  half_reg = HALF_RESET;
    int                 walk_x = 0;
    int                 walk_y = 0;
    logic [14:0]        new_cell_count = '0;
    bit                 cell_seen [int];

    walk_result_t       pending_results [$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    logic [DIR_W-1:0]   walk_bias_dir = DIR_UP;
    int                 walk_bias_pct = 0;

    lattice_walk_coverage #(
        .MAX_HALF(MAX_HALF)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_direction     (s_direction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_visited_count (m_visited_count),
        .m_cell_total    (m_cell_total)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Clamp the raw register into the usable range of bounds.
    function automatic int walk_bound();
        if (half_reg == 0) begin
            return 1;
        end
        if (half_reg > MAX_HALF) begin
            return MAX_HALF;
        end
        return int'(half_reg);
    endfunction

    // Drop the current walk: empty map, walker at the origin, count zero.
    task automatic clear_walk();
        cell_seen.delete();
        walk_x = 0;
        walk_y = 0;
        new_cell_count = '0;
    endtask

    // Mark the walker's cell, move it, and report whether it hit the edge.
    task automatic advance_walker(input logic [DIR_W-1:0] dir, output bit ended,
                                  output walk_result_t res);
        int bound;
        int cell_index;
        int side;
        bound = walk_bound();
        cell_index = ((walk_x + MAX_HALF) * MAP_SIDE + (walk_y + MAX_HALF))
                     % (MAP_SIDE * MAP_SIDE);
        if (!cell_seen.exists(cell_index)) begin
            cell_seen[cell_index] = 1'b1;
            new_cell_count = new_cell_count + 15'd1;
        end
        case (dir)
            DIR_UP: begin
                walk_y++;
            end
            DIR_RIGHT: begin
                walk_x++;
            end
            DIR_DOWN: begin
                walk_y--;
            end
            default: begin
                walk_x--;
            end
        endcase
        ended = (walk_x >= bound) || (walk_x <= -bound) || (walk_y >= bound) || (walk_y <= -bound);
        side = 2 * bound - 1;
        res.visited_count = new_cell_count[COUNT_W-1:0];
        res.cell_total = COUNT_W'(side * side);
        if (ended) begin
            clear_walk();
        end
    endtask

    // Choose a drift for the next walk; wide squares need a strong drift to
    // reach the edge within a sensible number of steps.
    task automatic pick_bias();
        walk_bias_dir = DIR_W'($urandom_range(0, 3));
        if (walk_bound() > 8) begin
            walk_bias_pct = $urandom_range(55, 90);
        end else begin
            walk_bias_pct = $urandom_range(0, 60);
        end
    endtask

    // Offer one step; hold valid and payload until the block takes it, then
    // advance the model and queue the result the step causes, if any.
    task automatic send_step(input logic [DIR_W-1:0] dir, input logic has_want,
                             input walk_result_t want);
        bit           ended;
        walk_result_t got;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_direction <= dir;
        do @(posedge aclk); while (!s_ready);
        advance_walker(dir, ended, got);
        if (ended) begin
            pending_results.push_back(has_want ? want : got);
            pick_bias();
        end
    endtask

    // Stop sending and hold until every queued result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write a register once the block is quiet (results drained, clear pass
    // over), mirror it in the model, and read half_size back.
    task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] readback;
        drain_results();
        repeat (SETTLE_CYC) @(posedge aclk);
        apb_write(addr, data);
        if (addr == ADDR_HALF_SIZE) begin
            half_reg = data[HALF_W-1:0];
            clear_walk();
        end
        apb_read(ADDR_HALF_SIZE, readback);
        if (readback !== PDATA_W'(half_reg)) begin
            report_mismatch("half_size readback", int'(readback), int'(half_reg));
        end
    endtask

    // Result side: check every transaction against the oldest expectation,
    // then pick the ready for the next cycle.
    always @(posedge aclk) begin
        walk_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, visited_count",
                                int'(m_visited_count), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_visited_count !== want.visited_count) begin
                    report_mismatch("visited_count", int'(m_visited_count),
                                    int'(want.visited_count));
                end
                if (m_cell_total !== want.cell_total) begin
                    report_mismatch("cell_total", int'(m_cell_total), int'(want.cell_total));
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        walk_row_t        row;
        logic [PDATA_W-1:0] data;
        logic [DIR_W-1:0] dir;
        int               pick;
        int               half_pick;

        // Hold reset, then let the post-reset clear pass run;
        // the first step simply waits for s_ready.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, no idling on either side.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                program_reg(row.addr, row.data);
            end else begin
                send_step(row.dir, row.has_want, row.want);
            end
        end

        // Random phases: a fresh bound each time, four idling patterns.
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 80;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 80;
                end
                default: begin
                    sender_idle_pct = 37;
                    receiver_stall_pct = 37;
                end
            endcase

            // Mostly narrow squares so walks end often; now and then the
            // widest, a middle width, an out-of-range value or zero.
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                half_pick = $urandom_range(1, 8);
            end else if (pick == 6) begin
                half_pick = $urandom_range(9, 63);
            end else if (pick == 7) begin
                half_pick = MAX_HALF;
            end else if (pick == 8) begin
                half_pick = $urandom_range(MAX_HALF + 1, 127);
            end else begin
                half_pick = 0;
            end
            data = $urandom();
            data[HALF_W-1:0] = HALF_W'(half_pick);
            program_reg(ADDR_HALF_SIZE, data);
            pick_bias();

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Halfway through, pause the sender until all results are in.
                if (i == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                if ($urandom_range(0, 99) < walk_bias_pct) begin
                    dir = walk_bias_dir;
                end else begin
                    dir = DIR_W'($urandom_range(0, 3));
                end
                send_step(dir, 1'b0, '0);
            end
        end

        // Drain, give the block time to finish, then give the verdict.
        drain_results();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
sv/lwc_pkg.sv
sv/lwc_map_ram.sv
sv/lwc_bound.sv
sv/lwc_walker.sv
sv/lattice_walk_coverage.sv
sv/lwc_checker.sv
dv/tb_top.sv
